// ===== hw/rtl/pfa_pkg.sv =====
package pfa_pkg;

	// widths fixed by the request and result fields
	localparam int ADDR_W = 31;
	localparam int HDR_W = 16;
	localparam int AMT_W = 32;
	// signed working width for gap, leftover and length arithmetic
	localparam int DW = 35;
	// widest slot index that the table supports (up to 16 slots)
	localparam int SLOT_AW = 4;

	typedef logic signed [DW-1:0] dword_t;

	typedef enum logic [1:0] {
		OP_ALLOC_PRI = 2'd0,
		OP_ALLOC_EXT = 2'd1,
		OP_RELEASE   = 2'd2,
		OP_RESIZE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_SLOT   = 3'd1,
		ST_NO_SPACE  = 3'd2,
		ST_SHRINK    = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_t;

	typedef enum logic [1:0] {
		REG_DISK_SIZE   = 2'd0,
		REG_HEADER_SIZE = 2'd1,
		REG_FIT_MODE    = 2'd2
	} reg_idx_t;

	localparam logic [HDR_W-1:0] HEADER_RESET = 16'd128;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RES_END,
		S_SCAN,
		S_ROOM,
		S_LEFT,
		S_NEXT,
		S_LEN_UPD,
		S_COMMIT,
		S_FIN
	} state_t;

	// write request into the slot table
	typedef struct packed {
		logic               set;
		logic               clr;
		logic               len_we;
		logic [SLOT_AW-1:0] addr;
		logic [ADDR_W-1:0]  start;
		logic [ADDR_W-1:0]  len;
	} tbl_wr_t;

endpackage

// ===== hw/rtl/pfa_alu.sv =====
module pfa_alu (
	input  pfa_pkg::dword_t a,
	input  pfa_pkg::dword_t b,
	input  logic            sub,
	output pfa_pkg::dword_t y
);

	// shared add / subtract used by the sequencer's arithmetic steps
	always_comb begin
		if (sub) begin
			y = a - b;
		end else begin
			y = a + b;
		end
	end

endmodule

// ===== hw/rtl/pfa_slot_table.sv =====
module pfa_slot_table #(
	parameter int NSLOTS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pfa_pkg::tbl_wr_t                   wr,
	input  logic [$clog2(NSLOTS)-1:0]          rd_addr,
	output logic [NSLOTS-1:0]                  valid_vec,
	output logic [pfa_pkg::ADDR_W-1:0]         rd_start,
	output logic [pfa_pkg::ADDR_W-1:0]         rd_len
);

	localparam int SW = $clog2(NSLOTS);

	logic [NSLOTS-1:0]                 valid_q;
	logic [pfa_pkg::ADDR_W-1:0]        start_q [NSLOTS];
	logic [pfa_pkg::ADDR_W-1:0]        len_q [NSLOTS];

	// occupancy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.set) begin
			valid_q[wr.addr[SW-1:0]] <= 1'b1;
		end else if (wr.clr) begin
			valid_q[wr.addr[SW-1:0]] <= 1'b0;
		end
	end

	// segment start and length, meaningful only while the slot is valid
	always_ff @(posedge clk) begin
		if (wr.set) begin
			start_q[wr.addr[SW-1:0]] <= wr.start;
			len_q[wr.addr[SW-1:0]]   <= wr.len;
		end else if (wr.len_we) begin
			len_q[wr.addr[SW-1:0]]   <= wr.len;
		end
	end

	assign valid_vec = valid_q;
	assign rd_start  = start_q[rd_addr];
	assign rd_len    = len_q[rd_addr];

endmodule

// ===== hw/rtl/pfa_seq.sv =====
module pfa_seq #(
	parameter int PRIMARY_SLOTS = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic [1:0]                          slot_index,
	input  logic signed [pfa_pkg::AMT_W-1:0]    amount,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          status,
	output logic [pfa_pkg::ADDR_W-1:0]          start_addr,
	output logic [1:0]                          slot_used,
	// configuration
	input  logic [pfa_pkg::ADDR_W-1:0]          disk_size,
	input  logic [pfa_pkg::HDR_W-1:0]           header_size,
	input  logic [1:0]                          fit_mode,
	// slot table
	input  logic [PRIMARY_SLOTS:0]              valid_vec,
	output logic [$clog2(PRIMARY_SLOTS+1)-1:0]  rd_addr,
	input  logic [pfa_pkg::ADDR_W-1:0]          rd_start,
	input  logic [pfa_pkg::ADDR_W-1:0]          rd_len,
	output pfa_pkg::tbl_wr_t                    wr
);

	localparam int NSLOTS = PRIMARY_SLOTS + 1;
	localparam int SW = $clog2(NSLOTS);
	localparam int AW = pfa_pkg::ADDR_W;

	pfa_pkg::state_t st_q, st_d;

	// request registers
	pfa_pkg::op_t                    op_q;
	logic [1:0]                      idx_q;
	logic signed [pfa_pkg::AMT_W-1:0] amount_q;
	logic [SW-1:0]                   slot_q;

	// ordered walk registers
	logic [SW-1:0]                   j_q;
	logic                            cand_v_q;
	logic [SW-1:0]                   cand_idx_q;
	logic [AW-1:0]                   cand_start_q;
	logic                            have_prev_q;
	logic [AW-1:0]                   prev_start_q;
	logic [SW-1:0]                   prev_idx_q;
	pfa_pkg::dword_t                 prev_end_q;
	pfa_pkg::dword_t                 room_q;
	logic                            found_q;
	pfa_pkg::dword_t                 best_q;
	logic [AW-1:0]                   where_q;

	// result in progress
	pfa_pkg::status_t                status_q;
	logic [AW-1:0]                   addr_q;
	logic [1:0]                      used_q;

	// output register
	logic                            out_valid_q;
	pfa_pkg::status_t                out_status_q;
	logic [AW-1:0]                   out_addr_q;
	logic [1:0]                      out_used_q;

	// shared unit
	pfa_pkg::dword_t                 alu_a, alu_b, alu_y;
	logic                            alu_sub;

	// decoded conditions
	logic [SW-1:0]                   idx_w;
	logic                            idx_ok;
	logic                            amt_lt1;
	pfa_pkg::dword_t                 amt_x;
	logic                            pri_found;
	logic [SW-1:0]                   pri_slot;
	logic                            slot_ok;
	logic                            scan_hit;
	logic                            last_j;
	logic                            take;
	logic                            first_like;
	logic                            y_lt1;
	logic                            fin_go;

	pfa_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	assign idx_w   = SW'(idx_q);
	assign idx_ok  = (32'(idx_q) < NSLOTS) && valid_vec[idx_w];
	assign amt_lt1 = amount_q[pfa_pkg::AMT_W-1] || (amount_q == '0);
	assign amt_x   = {{(pfa_pkg::DW-pfa_pkg::AMT_W){amount_q[pfa_pkg::AMT_W-1]}}, amount_q};
	assign y_lt1   = alu_y[pfa_pkg::DW-1] || (alu_y == '0);
	assign last_j  = (j_q == SW'(NSLOTS - 1));
	assign first_like = (fit_mode != pfa_pkg::FIT_BEST) && (fit_mode != pfa_pkg::FIT_WORST);
	assign fin_go  = !out_valid_q || out_ready;

	// first empty primary slot
	always_comb begin
		pri_found = 1'b0;
		pri_slot  = '0;
		for (int i = 0; i < PRIMARY_SLOTS; i++) begin
			if (!valid_vec[i] && !pri_found) begin
				pri_found = 1'b1;
				pri_slot  = SW'(i);
			end
		end
	end

	assign slot_ok = (op_q == pfa_pkg::OP_ALLOC_PRI) ? pri_found : !valid_vec[NSLOTS-1];

	// next slot in start order: key above the previous one, below the candidate
	assign scan_hit = valid_vec[j_q]
		&& (!have_prev_q || (rd_start > prev_start_q)
			|| ((rd_start == prev_start_q) && (j_q > prev_idx_q)))
		&& (!cand_v_q || (rd_start < cand_start_q));

	// placement decision on the leftover of the current gap
	assign take = !alu_y[pfa_pkg::DW-1]
		&& (!found_q
			|| ((fit_mode == pfa_pkg::FIT_BEST) && (alu_y < best_q))
			|| ((fit_mode == pfa_pkg::FIT_WORST) && (alu_y > best_q)));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pfa_pkg::S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state, table access and shared unit operands
	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		rd_addr  = idx_w;
		alu_a    = '0;
		alu_b    = '0;
		alu_sub  = 1'b0;
		wr       = '0;
		unique case (st_q)
			pfa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					st_d = pfa_pkg::S_DISPATCH;
				end
			end
			pfa_pkg::S_DISPATCH: begin
				if (op_q == pfa_pkg::OP_ALLOC_PRI || op_q == pfa_pkg::OP_ALLOC_EXT) begin
					if (!slot_ok || amt_lt1) begin
						st_d = pfa_pkg::S_FIN;
					end else begin
						st_d = pfa_pkg::S_SCAN;
					end
				end else if (!idx_ok) begin
					st_d = pfa_pkg::S_FIN;
				end else if (op_q == pfa_pkg::OP_RELEASE) begin
					wr.clr  = 1'b1;
					wr.addr = pfa_pkg::SLOT_AW'(idx_w);
					st_d    = pfa_pkg::S_FIN;
				end else if (amt_lt1) begin
					st_d = pfa_pkg::S_LEN_UPD;
				end else begin
					st_d = pfa_pkg::S_RES_END;
				end
			end
			pfa_pkg::S_RES_END: begin
				alu_a = pfa_pkg::DW'(rd_start);
				alu_b = pfa_pkg::DW'(rd_len);
				st_d  = pfa_pkg::S_SCAN;
			end
			pfa_pkg::S_SCAN: begin
				rd_addr = j_q;
				if (last_j) begin
					st_d = pfa_pkg::S_ROOM;
				end
			end
			pfa_pkg::S_ROOM: begin
				alu_a   = cand_v_q ? pfa_pkg::DW'(cand_start_q) : pfa_pkg::DW'(disk_size);
				alu_b   = prev_end_q;
				alu_sub = 1'b1;
				st_d    = pfa_pkg::S_LEFT;
			end
			pfa_pkg::S_LEFT: begin
				alu_a   = room_q;
				alu_b   = amt_x;
				alu_sub = 1'b1;
				if (op_q == pfa_pkg::OP_RESIZE) begin
					st_d = alu_y[pfa_pkg::DW-1] ? pfa_pkg::S_FIN : pfa_pkg::S_LEN_UPD;
				end else if (take && first_like) begin
					st_d = pfa_pkg::S_COMMIT;
				end else if (cand_v_q) begin
					st_d = pfa_pkg::S_NEXT;
				end else if (found_q || take) begin
					st_d = pfa_pkg::S_COMMIT;
				end else begin
					st_d = pfa_pkg::S_FIN;
				end
			end
			pfa_pkg::S_NEXT: begin
				rd_addr = cand_idx_q;
				alu_a   = pfa_pkg::DW'(cand_start_q);
				alu_b   = pfa_pkg::DW'(rd_len);
				st_d    = pfa_pkg::S_SCAN;
			end
			pfa_pkg::S_LEN_UPD: begin
				alu_a = pfa_pkg::DW'(rd_len);
				alu_b = amt_x;
				if (!(amt_lt1 && y_lt1)) begin
					wr.len_we = 1'b1;
					wr.addr   = pfa_pkg::SLOT_AW'(idx_w);
					wr.len    = alu_y[AW-1:0];
				end
				st_d = pfa_pkg::S_FIN;
			end
			pfa_pkg::S_COMMIT: begin
				wr.set   = 1'b1;
				wr.addr  = pfa_pkg::SLOT_AW'(slot_q);
				wr.start = where_q;
				wr.len   = amount_q[AW-1:0];
				st_d     = pfa_pkg::S_FIN;
			end
			pfa_pkg::S_FIN: begin
				if (fin_go) begin
					st_d = pfa_pkg::S_IDLE;
				end
			end
			default: begin
				st_d = pfa_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (st_q)
			pfa_pkg::S_IDLE: begin
				op_q     <= pfa_pkg::op_t'(opcode);
				idx_q    <= slot_index;
				amount_q <= amount;
				status_q <= pfa_pkg::ST_OK;
				addr_q   <= '0;
				used_q   <= '0;
			end
			pfa_pkg::S_DISPATCH: begin
				slot_q       <= (op_q == pfa_pkg::OP_ALLOC_PRI) ? pri_slot : SW'(NSLOTS - 1);
				prev_end_q   <= pfa_pkg::DW'(header_size);
				have_prev_q  <= 1'b0;
				cand_v_q     <= 1'b0;
				found_q      <= 1'b0;
				j_q          <= '0;
				if (op_q == pfa_pkg::OP_ALLOC_PRI || op_q == pfa_pkg::OP_ALLOC_EXT) begin
					if (!slot_ok) begin
						status_q <= pfa_pkg::ST_NO_SLOT;
					end else if (amt_lt1) begin
						status_q <= pfa_pkg::ST_NO_SPACE;
					end
				end else begin
					used_q <= idx_q;
					if (!idx_ok) begin
						status_q <= pfa_pkg::ST_EMPTY;
					end else begin
						addr_q <= rd_start;
					end
				end
			end
			pfa_pkg::S_RES_END: begin
				prev_end_q   <= alu_y;
				prev_start_q <= rd_start;
				prev_idx_q   <= idx_w;
				have_prev_q  <= 1'b1;
			end
			pfa_pkg::S_SCAN: begin
				if (scan_hit) begin
					cand_v_q     <= 1'b1;
					cand_idx_q   <= j_q;
					cand_start_q <= rd_start;
				end
				j_q <= last_j ? '0 : j_q + 1'b1;
			end
			pfa_pkg::S_ROOM: begin
				room_q <= alu_y;
			end
			pfa_pkg::S_LEFT: begin
				if (op_q == pfa_pkg::OP_RESIZE) begin
					if (alu_y[pfa_pkg::DW-1]) begin
						status_q <= pfa_pkg::ST_NO_SPACE;
					end
				end else begin
					if (take) begin
						found_q <= 1'b1;
						best_q  <= alu_y;
						where_q <= prev_end_q[AW-1:0];
					end
					if (!(take && first_like) && !cand_v_q && !found_q && !take) begin
						status_q <= pfa_pkg::ST_NO_SPACE;
					end
				end
			end
			pfa_pkg::S_NEXT: begin
				prev_end_q   <= alu_y;
				prev_start_q <= cand_start_q;
				prev_idx_q   <= cand_idx_q;
				have_prev_q  <= 1'b1;
				cand_v_q     <= 1'b0;
			end
			pfa_pkg::S_LEN_UPD: begin
				if (amt_lt1 && y_lt1) begin
					status_q <= pfa_pkg::ST_SHRINK;
				end
			end
			pfa_pkg::S_COMMIT: begin
				addr_q <= where_q;
				used_q <= 2'(slot_q);
			end
			default: begin
			end
		endcase
	end

	// result register, refilled once the previous transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == pfa_pkg::S_FIN && fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == pfa_pkg::S_FIN && fin_go) begin
			out_status_q <= status_q;
			out_addr_q   <= addr_q;
			out_used_q   <= used_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign start_addr = out_addr_q;
	assign slot_used  = out_used_q;

endmodule

// ===== hw/rtl/partition_fit_allocator.sv =====
// Segment allocator over a table of PRIMARY_SLOTS primary slots plus one
// extended slot (the last index). Requests: allocate primary, allocate
// extended, release, resize; each gives one result. Allocation walks the
// occupied slots in start order and places the segment in a gap by first,
// best (least leftover) or worst (largest leftover) fit. One request is in
// work at a time; a small sequencer finds each next slot in start order by
// sweeping the table one entry per cycle and runs every gap computation
// through one shared 35-bit add/subtract unit. The result sits in an output
// register, so the next request is taken while it waits. Configuration is
// written at any time through the cfg port, which is always ready, but must
// only change while no request is in work.
module partition_fit_allocator #(
	parameter int PRIMARY_SLOTS = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        opcode,
	input  logic [1:0]                        slot_index,
	input  logic signed [pfa_pkg::AMT_W-1:0]  amount,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        status,
	output logic [pfa_pkg::ADDR_W-1:0]        start_addr,
	output logic [1:0]                        slot_used,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [31:0]                       cfg_data
);

	localparam int NSLOTS = PRIMARY_SLOTS + 1;
	localparam int SW = $clog2(NSLOTS);

	logic [pfa_pkg::ADDR_W-1:0]  disk_size_q;
	logic [pfa_pkg::HDR_W-1:0]   header_size_q;
	logic [1:0]                  fit_mode_q;

	logic [NSLOTS-1:0]           valid_vec;
	logic [SW-1:0]               rd_addr;
	logic [pfa_pkg::ADDR_W-1:0]  rd_start;
	logic [pfa_pkg::ADDR_W-1:0]  rd_len;
	pfa_pkg::tbl_wr_t            wr;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_size_q   <= '0;
			header_size_q <= pfa_pkg::HEADER_RESET;
			fit_mode_q    <= pfa_pkg::FIT_FIRST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pfa_pkg::REG_DISK_SIZE:   disk_size_q   <= cfg_data[pfa_pkg::ADDR_W-1:0];
				pfa_pkg::REG_HEADER_SIZE: header_size_q <= cfg_data[pfa_pkg::HDR_W-1:0];
				pfa_pkg::REG_FIT_MODE:    fit_mode_q    <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	pfa_slot_table #(
		.NSLOTS (NSLOTS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.valid_vec (valid_vec),
		.rd_start  (rd_start),
		.rd_len    (rd_len)
	);

	pfa_seq #(
		.PRIMARY_SLOTS (PRIMARY_SLOTS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.slot_index  (slot_index),
		.amount      (amount),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.start_addr  (start_addr),
		.slot_used   (slot_used),
		.disk_size   (disk_size_q),
		.header_size (header_size_q),
		.fit_mode    (fit_mode_q),
		.valid_vec   (valid_vec),
		.rd_addr     (rd_addr),
		.rd_start    (rd_start),
		.rd_len      (rd_len),
		.wr          (wr)
	);

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

	localparam int PRIMARY = 3;
	localparam int NSLOTS = PRIMARY + 1;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int RX_HOLD = 400;
	localparam int PHASES = 31;
	localparam int PHASE_ITEMS = 50;

	// one result transaction as the allocator reports it
	typedef struct packed {
		logic [2:0]                 status;
		logic [pfa_pkg::ADDR_W-1:0] start;
		logic [1:0]                 slot;
	} alloc_outcome_t;

	// shadow slot table, expected outcomes and mismatch bookkeeping
	class alloc_scoreboard;
		bit                         seg_valid[NSLOTS];
		bit [pfa_pkg::ADDR_W-1:0]   seg_start[NSLOTS];
		bit [pfa_pkg::ADDR_W-1:0]   seg_len[NSLOTS];
		bit [pfa_pkg::ADDR_W-1:0]   disk_bytes;
		bit [pfa_pkg::HDR_W-1:0]    hdr_bytes;
		logic [1:0]                 fit_sel;
		int                         ord[NSLOTS];
		int                         nocc;
		alloc_outcome_t             outcome_q[$];
		int                         mismatches;

		function new();
			for (int i = 0; i < NSLOTS; i++) begin
				seg_valid[i] = 1'b0;
				seg_start[i] = '0;
				seg_len[i] = '0;
			end
			disk_bytes = '0;
			hdr_bytes = pfa_pkg::HEADER_RESET;
			fit_sel = pfa_pkg::FIT_FIRST;
			nocc = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch: %s", $time, msg);
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				pfa_pkg::REG_DISK_SIZE:   disk_bytes = data[pfa_pkg::ADDR_W-1:0];
				pfa_pkg::REG_HEADER_SIZE: hdr_bytes = data[pfa_pkg::HDR_W-1:0];
				pfa_pkg::REG_FIT_MODE:    fit_sel = data[1:0];
				default: ;
			endcase
		endfunction

		// occupied slots in start order, ties kept in index order
		function void sort_occupied();
			int j;
			nocc = 0;
			for (int i = 0; i < NSLOTS; i++) begin
				if (seg_valid[i]) begin
					j = nocc;
					while (j > 0 && seg_start[ord[j-1]] > seg_start[i]) begin
						ord[j] = ord[j-1];
						j--;
					end
					ord[j] = i;
					nocc++;
				end
			end
		endfunction

		// gap search under the current fit policy
		function bit find_gap(longint size, output longint spot);
			longint prev_end, gap_end, left, best_left, s0, l0;
			bit found, take;
			sort_occupied();
			prev_end = hdr_bytes;
			found = 1'b0;
			best_left = 0;
			spot = 0;
			for (int k = 0; k <= nocc; k++) begin
				if (k < nocc)
					gap_end = seg_start[ord[k]];
				else
					gap_end = disk_bytes;
				left = gap_end - prev_end - size;
				if (left >= 0) begin
					if (!found)
						take = 1'b1;
					else if (fit_sel == pfa_pkg::FIT_BEST)
						take = left < best_left;
					else if (fit_sel == pfa_pkg::FIT_WORST)
						take = left > best_left;
					else
						take = 1'b0;
					if (take) begin
						found = 1'b1;
						best_left = left;
						spot = prev_end;
						if (fit_sel != pfa_pkg::FIT_BEST && fit_sel != pfa_pkg::FIT_WORST)
							return 1'b1;
					end
				end
				if (k < nocc) begin
					s0 = seg_start[ord[k]];
					l0 = seg_len[ord[k]];
					prev_end = s0 + l0;
				end
			end
			return found;
		endfunction

		// end of the free space right of slot s
		function longint right_edge(int s);
			longint e;
			sort_occupied();
			e = disk_bytes;
			for (int k = 0; k < nocc; k++) begin
				if (ord[k] == s && k + 1 < nocc)
					e = seg_start[ord[k+1]];
			end
			return e;
		endfunction

		// accepted request: update the shadow table and queue the outcome
		function void note_request(logic [1:0] op, logic [1:0] idx, logic signed [31:0] amt);
			alloc_outcome_t res;
			longint a, spot, nl, sl, ln, free_bytes;
			int s;
			a = amt;
			res.status = pfa_pkg::ST_OK;
			res.start = '0;
			res.slot = '0;
			if (op == pfa_pkg::OP_ALLOC_PRI || op == pfa_pkg::OP_ALLOC_EXT) begin
				s = NSLOTS;
				if (op == pfa_pkg::OP_ALLOC_PRI) begin
					for (int i = PRIMARY - 1; i >= 0; i--)
						if (!seg_valid[i])
							s = i;
				end else if (!seg_valid[PRIMARY]) begin
					s = PRIMARY;
				end
				if (s >= NSLOTS) begin
					res.status = pfa_pkg::ST_NO_SLOT;
				end else if (a < 1 || !find_gap(a, spot)) begin
					res.status = pfa_pkg::ST_NO_SPACE;
				end else begin
					seg_valid[s] = 1'b1;
					seg_start[s] = spot[pfa_pkg::ADDR_W-1:0];
					seg_len[s] = a[pfa_pkg::ADDR_W-1:0];
					res.start = seg_start[s];
					res.slot = s[1:0];
				end
			end else begin
				res.slot = idx;
				if (idx >= NSLOTS || !seg_valid[idx]) begin
					res.status = pfa_pkg::ST_EMPTY;
				end else begin
					res.start = seg_start[idx];
					sl = seg_start[idx];
					ln = seg_len[idx];
					if (op == pfa_pkg::OP_RELEASE) begin
						seg_valid[idx] = 1'b0;
						seg_start[idx] = '0;
						seg_len[idx] = '0;
					end else if (a < 1) begin
						nl = ln + a;
						if (nl < 1)
							res.status = pfa_pkg::ST_SHRINK;
						else
							seg_len[idx] = nl[pfa_pkg::ADDR_W-1:0];
					end else begin
						free_bytes = right_edge(idx) - (sl + ln);
						if (free_bytes < a) begin
							res.status = pfa_pkg::ST_NO_SPACE;
						end else begin
							nl = ln + a;
							seg_len[idx] = nl[pfa_pkg::ADDR_W-1:0];
						end
					end
				end
			end
			outcome_q = {outcome_q, res};
		endfunction

		function void check_result(logic [2:0] st, logic [pfa_pkg::ADDR_W-1:0] addr,
				logic [1:0] slot);
			alloc_outcome_t exp_res;
			if (outcome_q.size() == 0) begin
				flag($sformatf("result with nothing pending: status %0d start %0d slot %0d",
					st, addr, slot));
				return;
			end
			exp_res = outcome_q.pop_front();
			if (st !== exp_res.status)
				flag($sformatf("status expected %0d got %0d", exp_res.status, st));
			if (addr !== exp_res.start)
				flag($sformatf("start_addr expected %0d got %0d", exp_res.start, addr));
			if (slot !== exp_res.slot)
				flag($sformatf("slot_used expected %0d got %0d", exp_res.slot, slot));
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = '0;
	logic [1:0] slot_index = '0;
	logic signed [pfa_pkg::AMT_W-1:0] amount = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [pfa_pkg::ADDR_W-1:0] start_addr;
	logic [1:0] slot_used;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	alloc_scoreboard sb = new();

	// stimulus steering shared by the sender and receiver
	bit calm = 1'b0;
	bit rx_hold_req = 1'b0;
	longint cur_disk = 0;
	longint cur_hdr = 128;

	partition_fit_allocator #(
		.PRIMARY_SLOTS(PRIMARY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.slot_index(slot_index),
		.amount(amount),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.start_addr(start_addr),
		.slot_used(slot_used),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(status, start_addr, slot_used);
			if (in_valid && in_ready)
				sb.note_request(opcode, slot_index, amount);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result receiver with random backpressure and one long hold
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				g = idle_len();
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	task automatic send_request(input logic [1:0] op, input logic [1:0] idx,
			input logic [31:0] amt);
		int g;
		in_valid <= 1'b1;
		opcode <= op;
		slot_index <= idx;
		amount <= amt;
		do @(posedge clk); while (!in_ready);
		g = idle_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering requests until every outcome is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_disk(input longint d);
		logic [31:0] data;
		data = $urandom;
		data[pfa_pkg::ADDR_W-1:0] = d[pfa_pkg::ADDR_W-1:0];
		cur_disk = d;
		write_reg(pfa_pkg::REG_DISK_SIZE, data);
	endtask

	task automatic set_header(input longint h);
		logic [31:0] data;
		data = $urandom;
		data[pfa_pkg::HDR_W-1:0] = h[pfa_pkg::HDR_W-1:0];
		cur_hdr = h;
		write_reg(pfa_pkg::REG_HEADER_SIZE, data);
	endtask

	task automatic set_fit(input logic [1:0] mode);
		logic [31:0] data;
		data = $urandom;
		data[1:0] = mode;
		write_reg(pfa_pkg::REG_FIT_MODE, data);
	endtask

	// phase settings, extremes forced in the first phases
	task automatic set_config(input int ph);
		longint h, d;
		case ($urandom_range(0, 9))
			0: h = 0;
			1: h = 65535;
			default: h = $urandom_range(0, 300);
		endcase
		case ($urandom_range(0, 9))
			0: d = 0;
			1: d = 31'h7FFF_FFFF;
			2: d = $urandom_range(0, 600);
			default: d = h + $urandom_range(200, 20000);
		endcase
		if (ph == 1) begin
			h = 65535;
			d = 31'h7FFF_FFFF;
		end else if (ph == 2) begin
			h = 0;
			d = 0;
		end
		set_header(h);
		set_disk(d);
		set_fit(2'(ph % 4));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, $urandom);
	endtask

	function automatic logic [31:0] pick_amount(input logic [1:0] op);
		longint span, v;
		int r;
		span = cur_disk - cur_hdr;
		if (span < 8)
			span = 8;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom;
		if (r < 14) begin
			case ($urandom_range(0, 4))
				0: return 32'h0000_0000;
				1: return 32'h0000_0001;
				2: return 32'hFFFF_FFFF;
				3: return 32'h7FFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		end
		if (op == pfa_pkg::OP_RESIZE) begin
			if (r < 20)
				v = 0;
			else if (r < 60)
				v = $urandom_range(1, 32'(span / 8));
			else
				v = -longint'($urandom_range(1, 32'(span / 6)));
		end else begin
			v = $urandom_range(1, 32'(span / 3));
		end
		return v[31:0];
	endfunction

	task automatic run_phase(input int n_items);
		int r;
		logic [1:0] op;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 32)
				op = pfa_pkg::OP_ALLOC_PRI;
			else if (r < 48)
				op = pfa_pkg::OP_ALLOC_EXT;
			else if (r < 68)
				op = pfa_pkg::OP_RELEASE;
			else
				op = pfa_pkg::OP_RESIZE;
			send_request(op, 2'($urandom_range(0, 3)), pick_amount(op));
		end
	endtask

	// main sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero disk leaves no room
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd0, 32'd10);
		drain();
		set_disk(1000);
		set_header(100);
		set_fit(pfa_pkg::FIT_FIRST);

		// sizes below one byte, table fill, slot exhaustion
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd0, 32'd0);
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd0, 32'hFFFF_FFFF);
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd3, 32'd100);
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd1, 32'd200);
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd2, 32'd50);
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd0, 32'd10);
		send_request(pfa_pkg::OP_ALLOC_EXT, 2'd0, 32'd100);
		send_request(pfa_pkg::OP_ALLOC_EXT, 2'd0, 32'd10);
		// release twice, second one hits an empty slot
		send_request(pfa_pkg::OP_RELEASE, 2'd1, 32'd0);
		send_request(pfa_pkg::OP_RELEASE, 2'd1, 32'd0);
		// grow into the hole, grow with no gap, zero, shrink limits
		send_request(pfa_pkg::OP_RESIZE, 2'd0, 32'd100);
		send_request(pfa_pkg::OP_RESIZE, 2'd0, 32'd1);
		send_request(pfa_pkg::OP_RESIZE, 2'd0, 32'd0);
		send_request(pfa_pkg::OP_RESIZE, 2'd0, -32'sd200);
		send_request(pfa_pkg::OP_RESIZE, 2'd0, -32'sd199);
		send_request(pfa_pkg::OP_RESIZE, 2'd2, 32'h7FFF_FFFF);
		send_request(pfa_pkg::OP_RESIZE, 2'd2, 32'h8000_0000);
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd0, 32'h7FFF_FFFF);
		send_request(pfa_pkg::OP_RELEASE, 2'd3, 32'd0);
		drain();

		// best and worst fit, ties, then the unnamed mode
		set_fit(pfa_pkg::FIT_BEST);
		send_request(pfa_pkg::OP_ALLOC_EXT, 2'd0, 32'd5);
		send_request(pfa_pkg::OP_RELEASE, 2'd3, 32'd0);
		drain();
		set_fit(pfa_pkg::FIT_WORST);
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd0, 32'd5);
		drain();
		set_fit(2'd3);
		send_request(pfa_pkg::OP_ALLOC_EXT, 2'd0, 32'd5);
		drain();
		// header past occupied slots gives negative gaps
		set_header(65535);
		send_request(pfa_pkg::OP_ALLOC_PRI, 2'd0, 32'd1);
		send_request(pfa_pkg::OP_RESIZE, 2'd3, 32'd1);
		drain();

		// random phases
		for (int ph = 1; ph <= PHASES; ph++) begin
			drain();
			set_config(ph);
			calm = ($urandom_range(0, 4) == 0);
			if (ph == 3) begin
				calm = 1'b0;
				rx_hold_req = 1'b1;
			end
			run_phase(PHASE_ITEMS);
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// run limit
	initial begin
		#10000000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
